// ----- rtl/les_pkg.sv -----
package les_pkg;

	// Default word format of the point, signed fixed point.
	localparam int WORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 24;

	// Coefficient registers are unsigned and this wide, whatever the word width.
	localparam int COEF_W = 31;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SIGMA = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RHO   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BETA  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DT    = 2'd3;

	// Request kinds carried in the input tuser.
	localparam logic REQ_STEP = 1'b0;
	localparam logic REQ_LOAD = 1'b1;

	// Multiply operations of one Euler step, in issue order.
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] MUL_SIG_T1 = 3'd0; // sigma * (y - x)
	localparam logic [OP_W-1:0] MUL_X_T2   = 3'd1; // x * (rho - z)
	localparam logic [OP_W-1:0] MUL_X_Y    = 3'd2; // x * y
	localparam logic [OP_W-1:0] MUL_BETA_Z = 3'd3; // beta * z
	localparam logic [OP_W-1:0] MUL_M1_DT  = 3'd4; // dx
	localparam logic [OP_W-1:0] MUL_T4_DT  = 3'd5; // dz
	localparam logic [OP_W-1:0] MUL_T3_DT  = 3'd6; // dy

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            load;        // take the load fields into the point
		logic            start;       // a new item begins: clear the clamp flag
		logic            issue;       // start a multiply
		logic [OP_W-1:0] op;          // which multiply
		logic            commit_step; // write the stepped point and the result
		logic            commit_load; // write the loaded point as the result
	} cmd_t;

endpackage

// ----- rtl/les_ctrl.sv -----
module les_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              req_type,
	output logic              m_tvalid,
	input  logic              m_tready,
	output les_pkg::cmd_t     cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [2:0] LAST_SLOT = 3'd7;

	logic [1:0] state_q;
	logic [2:0] slot_q;
	logic       kind_q;
	logic       m_tvalid_q;
	logic       accept;
	logic       out_free;
	logic       commit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = (state_q == ST_DONE) && out_free;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd             = '0;
		cmd.load        = accept && (req_type == les_pkg::REQ_LOAD);
		cmd.start       = accept;
		cmd.commit_step = commit && (kind_q == les_pkg::REQ_STEP);
		cmd.commit_load = commit && (kind_q == les_pkg::REQ_LOAD);
		if (state_q == ST_RUN) begin
			cmd.issue = 1'b1;
			case (slot_q)
				3'd0: cmd.op = les_pkg::MUL_SIG_T1;
				3'd1: cmd.op = les_pkg::MUL_X_T2;
				3'd2: cmd.op = les_pkg::MUL_X_Y;
				3'd3: cmd.op = les_pkg::MUL_BETA_Z;
				3'd4: cmd.op = les_pkg::MUL_M1_DT;
				3'd5: cmd.op = les_pkg::MUL_T4_DT;
				3'd6: cmd.op = les_pkg::MUL_T3_DT;
				default: begin
					// Last slot only drains the multiplier.
					cmd.issue = 1'b0;
					cmd.op    = les_pkg::MUL_SIG_T1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_q     <= '0;
			kind_q     <= les_pkg::REQ_STEP;
			m_tvalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q  <= req_type;
						slot_q  <= '0;
						state_q <= (req_type == les_pkg::REQ_LOAD) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (slot_q == LAST_SLOT) begin
						state_q <= ST_DONE;
					end else begin
						slot_q <= slot_q + 3'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/les_dp.sv -----
module les_dp #(
	parameter int WordWidth = les_pkg::WORD_WIDTH_DEF,
	parameter int FracBits  = les_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  les_pkg::cmd_t                     cmd,
	input  logic                              cfg_we,
	input  logic [les_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [les_pkg::COEF_W-1:0]        cfg_data,
	input  logic [WordWidth-1:0]              load_x,
	input  logic [WordWidth-1:0]              load_y,
	input  logic [WordWidth-1:0]              load_z,
	output logic [WordWidth-1:0]              out_x,
	output logic [WordWidth-1:0]              out_y,
	output logic [WordWidth-1:0]              out_z,
	output logic                              saturated
);

	localparam int CW  = les_pkg::COEF_W;
	// Operand width covers both a coordinate and a coefficient as signed values.
	localparam int OpW = (WordWidth > CW + 1) ? WordWidth : CW + 1;
	localparam int LoW = OpW / 2;
	localparam int HiW = OpW - LoW;
	localparam int PW  = 2 * OpW;

	localparam logic [63:0] One      = 64'd1 << FracBits;
	localparam logic [CW-1:0] SigmaRst = CW'(One * 64'd10);
	localparam logic [CW-1:0] RhoRst   = CW'(One * 64'd28);
	localparam logic [CW-1:0] BetaRst  = CW'((One * 64'd8 + 64'd1) / 64'd3);
	localparam logic [CW-1:0] DtRst    = CW'((One + 64'd25) / 64'd50);
	localparam logic [WordWidth-1:0] PosRst = WordWidth'(One);

	function automatic logic signed [OpW:0] sxw(input logic [WordWidth-1:0] v);
		return {{(OpW + 1 - WordWidth){v[WordWidth-1]}}, v};
	endfunction

	function automatic logic signed [OpW:0] zc(input logic [CW-1:0] c);
		return {{(OpW + 1 - CW){1'b0}}, c};
	endfunction

	// Clamp to the word range; the top bit of the result flags a clamp.
	function automatic logic [WordWidth:0] clampw(input logic signed [OpW:0] v);
		logic same;
		same = (&v[OpW:WordWidth-1]) || !(|v[OpW:WordWidth-1]);
		if (same) begin
			return {1'b0, v[WordWidth-1:0]};
		end else if (v[OpW]) begin
			return {2'b11, {(WordWidth - 1){1'b0}}};
		end
		return {2'b10, {(WordWidth - 1){1'b1}}};
	endfunction

	function automatic logic [WordWidth:0] clampp(input logic signed [PW-1:0] v);
		logic same;
		same = (&v[PW-1:WordWidth-1]) || !(|v[PW-1:WordWidth-1]);
		if (same) begin
			return {1'b0, v[WordWidth-1:0]};
		end else if (v[PW-1]) begin
			return {2'b11, {(WordWidth - 1){1'b0}}};
		end
		return {2'b10, {(WordWidth - 1){1'b1}}};
	endfunction

	logic [CW-1:0]        sigma_q, rho_q, beta_q, dt_q;
	logic [WordWidth-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [WordWidth-1:0] m1_q, u_q, xy_q, bz_q, dx_q, dy_q, dz_q;
	logic                 sat_q;

	logic [WordWidth:0]   t1, t2, t3, t4;
	logic [WordWidth:0]   nx, ny, nz;
	logic signed [OpW-1:0] opa, opb;
	logic                 op_clamp;

	logic signed [OpW+LoW:0]   pp_lo;
	logic signed [OpW+HiW-1:0] pp_hi;
	logic signed [OpW+LoW:0]   pp_lo_s1;
	logic signed [OpW+HiW-1:0] pp_hi_s1;
	logic [les_pkg::OP_W-1:0]  op_s1;
	logic                      valid_s1;

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_sh;
	logic [WordWidth:0]   mres;

	// Bracket terms, each clamped on its own.
	assign t1 = clampw(sxw(pos_y_q) - sxw(pos_x_q));
	assign t2 = clampw(zc(rho_q) - sxw(pos_z_q));
	assign t3 = clampw(sxw(u_q) - sxw(pos_y_q));
	assign t4 = clampw(sxw(xy_q) - sxw(bz_q));

	assign nx = clampw(sxw(pos_x_q) + sxw(dx_q));
	assign ny = clampw(sxw(pos_y_q) + sxw(dy_q));
	assign nz = clampw(sxw(pos_z_q) + sxw(dz_q));

	always_comb begin
		opa      = OpW'(sxw(m1_q));
		opb      = OpW'(zc(dt_q));
		op_clamp = 1'b0;
		case (cmd.op)
			les_pkg::MUL_SIG_T1: begin
				opa      = OpW'(zc(sigma_q));
				opb      = OpW'(sxw(t1[WordWidth-1:0]));
				op_clamp = t1[WordWidth];
			end
			les_pkg::MUL_X_T2: begin
				opa      = OpW'(sxw(pos_x_q));
				opb      = OpW'(sxw(t2[WordWidth-1:0]));
				op_clamp = t2[WordWidth];
			end
			les_pkg::MUL_X_Y: begin
				opa = OpW'(sxw(pos_x_q));
				opb = OpW'(sxw(pos_y_q));
			end
			les_pkg::MUL_BETA_Z: begin
				opa = OpW'(zc(beta_q));
				opb = OpW'(sxw(pos_z_q));
			end
			les_pkg::MUL_M1_DT: begin
				opa = OpW'(sxw(m1_q));
			end
			les_pkg::MUL_T4_DT: begin
				opa      = OpW'(sxw(t4[WordWidth-1:0]));
				op_clamp = t4[WordWidth];
			end
			les_pkg::MUL_T3_DT: begin
				opa      = OpW'(sxw(t3[WordWidth-1:0]));
				op_clamp = t3[WordWidth];
			end
			default: begin
				opa = OpW'(sxw(m1_q));
			end
		endcase
	end

	// The multiplier is split on the second operand into two half-width products.
	assign pp_lo = opa * $signed({1'b0, opb[LoW-1:0]});
	assign pp_hi = opa * $signed(opb[OpW-1:LoW]);

	assign prod    = {pp_hi_s1, {LoW{1'b0}}} + {{(HiW - 1){pp_lo_s1[OpW+LoW]}}, pp_lo_s1};
	assign prod_sh = prod >>> FracBits;
	assign mres    = clampp(prod_sh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q  <= SigmaRst;
			rho_q    <= RhoRst;
			beta_q   <= BetaRst;
			dt_q     <= DtRst;
			pos_x_q  <= PosRst;
			pos_y_q  <= PosRst;
			pos_z_q  <= PosRst;
			valid_s1 <= 1'b0;
			sat_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					les_pkg::REG_SIGMA: sigma_q <= cfg_data;
					les_pkg::REG_RHO:   rho_q   <= cfg_data;
					les_pkg::REG_BETA:  beta_q  <= cfg_data;
					les_pkg::REG_DT:    dt_q    <= cfg_data;
					default: ;
				endcase
			end
			valid_s1 <= cmd.issue;
			if (cmd.start) begin
				sat_q <= 1'b0;
			end else begin
				sat_q <= sat_q | (cmd.issue & op_clamp) | (valid_s1 & mres[WordWidth]);
			end
			if (cmd.load) begin
				pos_x_q <= load_x;
				pos_y_q <= load_y;
				pos_z_q <= load_z;
			end else if (cmd.commit_step) begin
				pos_x_q <= nx[WordWidth-1:0];
				pos_y_q <= ny[WordWidth-1:0];
				pos_z_q <= nz[WordWidth-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		pp_lo_s1 <= pp_lo;
		pp_hi_s1 <= pp_hi;
		op_s1    <= cmd.op;
		if (valid_s1) begin
			case (op_s1)
				les_pkg::MUL_SIG_T1: m1_q <= mres[WordWidth-1:0];
				les_pkg::MUL_X_T2:   u_q  <= mres[WordWidth-1:0];
				les_pkg::MUL_X_Y:    xy_q <= mres[WordWidth-1:0];
				les_pkg::MUL_BETA_Z: bz_q <= mres[WordWidth-1:0];
				les_pkg::MUL_M1_DT:  dx_q <= mres[WordWidth-1:0];
				les_pkg::MUL_T4_DT:  dz_q <= mres[WordWidth-1:0];
				les_pkg::MUL_T3_DT:  dy_q <= mres[WordWidth-1:0];
				default: ;
			endcase
		end
		if (cmd.commit_step) begin
			out_x     <= nx[WordWidth-1:0];
			out_y     <= ny[WordWidth-1:0];
			out_z     <= nz[WordWidth-1:0];
			saturated <= sat_q | nx[WordWidth] | ny[WordWidth] | nz[WordWidth];
		end else if (cmd.commit_load) begin
			out_x     <= pos_x_q;
			out_y     <= pos_y_q;
			out_z     <= pos_z_q;
			saturated <= 1'b0;
		end
	end

endmodule

// ----- rtl/lorenz_euler_step_unit.sv -----
// Forward-Euler integrator for the Lorenz system in signed fixed point
// (WORD_WIDTH bits with FRAC_BITS fraction bits, Q8.24 by default). The unit
// holds one point (x, y, z), which reset sets to (1, 1, 1). A step beat on the
// input advances the point by dx = sigma(y-x)dt, dy = (x(rho-z)-y)dt and
// dz = (xy - beta z)dt; a load beat replaces the point with the given one.
// Every input beat yields exactly one output beat carrying the new point and
// a flag that is set when any intermediate or coordinate was clamped to the
// word range. Products are truncated toward minus infinity. The next input
// beat is taken in the cycle after the result is registered, both for a step
// and for a load. The step time is set by the seven products of the step,
// which share one multiplier with a partial-product stage and an accumulate
// stage, issued one per cycle in dependency order. The coefficients sigma,
// rho, beta and dt sit in four registers written through the configuration
// channel; the user must write them only while the unit is idle, as the unit
// itself does not enforce this.
module lorenz_euler_step_unit #(
	parameter int WORD_WIDTH = les_pkg::WORD_WIDTH_DEF,
	parameter int FRAC_BITS  = les_pkg::FRAC_BITS_DEF,
	parameter int S_DATA_W   = ((3 * WORD_WIDTH + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Input stream.
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// From bit 0 up: load_x, load_y, load_z, zero padding.
	input  logic [S_DATA_W-1:0]             s_tdata,
	// Bit 0: req_type (0 step, 1 load).
	input  logic [0:0]                      s_tuser,

	// Result stream.
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// From bit 0 up: out_x, out_y, out_z, zero padding.
	output logic [S_DATA_W-1:0]             m_tdata,
	// Bit 0: saturated.
	output logic [0:0]                      m_tuser,

	// Configuration writes: index 0 sigma, 1 rho, 2 beta, 3 dt.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [les_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [les_pkg::COEF_W-1:0]      cfg_data
);

	les_pkg::cmd_t          cmd;
	logic [WORD_WIDTH-1:0]  out_x, out_y, out_z;
	logic                   saturated;

	// Registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	les_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.req_type (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	les_dp #(
		.WordWidth (WORD_WIDTH),
		.FracBits  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load_x    (s_tdata[WORD_WIDTH-1:0]),
		.load_y    (s_tdata[2*WORD_WIDTH-1:WORD_WIDTH]),
		.load_z    (s_tdata[3*WORD_WIDTH-1:2*WORD_WIDTH]),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.saturated (saturated)
	);

	// Pack the result fields; any padding bits above them read as zero.
	always_comb begin
		m_tdata                               = '0;
		m_tdata[WORD_WIDTH-1:0]               = out_x;
		m_tdata[2*WORD_WIDTH-1:WORD_WIDTH]    = out_y;
		m_tdata[3*WORD_WIDTH-1:2*WORD_WIDTH]  = out_z;
	end

	assign m_tuser[0] = saturated;

endmodule

// ----- rtl/les_checker.sv -----
module les_prop_checker #(
	parameter int WORD_WIDTH = les_pkg::WORD_WIDTH_DEF,
	parameter int S_DATA_W   = ((3 * WORD_WIDTH + 7) / 8) * 8
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [S_DATA_W-1:0] s_tdata,
	input logic [0:0]          s_tuser,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [S_DATA_W-1:0] m_tdata,
	input logic [0:0]          m_tuser
);

	// A result beat that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A load comes back as the loaded point, unclamped, as soon as the output is free.
	a_load_echo: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser[0] == les_pkg::REQ_LOAD)) ##1 (!m_tvalid || m_tready)
		|=> m_tvalid && (m_tuser[0] == 1'b0)
			&& (m_tdata[3*WORD_WIDTH-1:0] == $past(s_tdata[3*WORD_WIDTH-1:0], 2)))
		else $error("load beat not returned as the loaded point");

	// A step keeps the input closed while its products are worked out.
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == les_pkg::REQ_STEP) |-> ##8 !s_tready)
		else $error("input reopened before the step finished");

endmodule

bind lorenz_euler_step_unit les_prop_checker #(
	.WORD_WIDTH (WORD_WIDTH),
	.S_DATA_W   (S_DATA_W)
) u_les_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- bench/les_checker.sv -----
module les_checker #(
	parameter int DW = 96
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [DW-1:0]                   s_tdata,
	input  logic [0:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [DW-1:0]                   m_tdata,
	input  logic [0:0]                      m_tuser,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [les_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [les_pkg::COEF_W-1:0]      cfg_data,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int WW = les_pkg::WORD_WIDTH_DEF;
	localparam int FB = les_pkg::FRAC_BITS_DEF;
	localparam longint WORD_HI = (longint'(1) <<< (WW - 1)) - 1;
	localparam longint WORD_LO = -WORD_HI - 1;

	typedef struct packed {
		logic signed [WW-1:0] x;
		logic signed [WW-1:0] y;
		logic signed [WW-1:0] z;
		logic                 sat;
	} point_t;

	longint sigma_q, rho_q, beta_q, dt_q;
	point_t cur_point, got, want;
	point_t expected_points[$];
	bit     clamp_seen;
	int     err_count = 0;

	function automatic longint clip(input longint v);
		if (v > WORD_HI) begin
			clamp_seen = 1'b1;
			return WORD_HI;
		end
		if (v < WORD_LO) begin
			clamp_seen = 1'b1;
			return WORD_LO;
		end
		return v;
	endfunction

	// Operands never exceed 2^31 in magnitude, so the product fits in 64 bits.
	function automatic longint qmul(input longint a, input longint b);
		return clip((a * b) >>> FB);
	endfunction

	function automatic point_t euler_advance(input point_t p);
		point_t r;
		longint x, y, z, t, u, dx, dy, dz;
		clamp_seen = 1'b0;
		x = $signed(p.x);
		y = $signed(p.y);
		z = $signed(p.z);
		t  = clip(y - x);
		u  = qmul(sigma_q, t);
		dx = qmul(u, dt_q);
		t  = clip(rho_q - z);
		u  = qmul(x, t);
		t  = clip(u - y);
		dy = qmul(t, dt_q);
		u  = qmul(x, y);
		t  = qmul(beta_q, z);
		t  = clip(u - t);
		dz = qmul(t, dt_q);
		r.x = WW'(clip(x + dx));
		r.y = WW'(clip(y + dy));
		r.z = WW'(clip(z + dz));
		r.sat = clamp_seen;
		return r;
	endfunction

	task automatic report_field(input string fld, input longint exp_v, input longint act_v);
		err_count++;
		$display("%0t: %s expected %0d actual %0d", $time, fld, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q = longint'(10) << FB;
			rho_q   = longint'(28) << FB;
			beta_q  = ((longint'(8) << FB) + 1) / 3;
			dt_q    = ((longint'(1) << FB) + 25) / 50;
			cur_point.x = 1 << FB;
			cur_point.y = 1 << FB;
			cur_point.z = 1 << FB;
			cur_point.sat = 1'b0;
			expected_points.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got.x = m_tdata[WW-1:0];
				got.y = m_tdata[2*WW-1:WW];
				got.z = m_tdata[3*WW-1:2*WW];
				got.sat = m_tuser[0];
				if (expected_points.size() == 0) begin
					report_field("unexpected result x", 0, got.x);
				end else begin
					want = expected_points.pop_front();
					if (got.x !== want.x)
						report_field("out_x", want.x, got.x);
					if (got.y !== want.y)
						report_field("out_y", want.y, got.y);
					if (got.z !== want.z)
						report_field("out_z", want.z, got.z);
					if (got.sat !== want.sat)
						report_field("saturated", want.sat, got.sat);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == les_pkg::REQ_LOAD) begin
					cur_point.x = s_tdata[WW-1:0];
					cur_point.y = s_tdata[2*WW-1:WW];
					cur_point.z = s_tdata[3*WW-1:2*WW];
					cur_point.sat = 1'b0;
				end else begin
					cur_point = euler_advance(cur_point);
				end
				expected_points = {expected_points, cur_point};
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					les_pkg::REG_SIGMA: sigma_q = longint'(cfg_data);
					les_pkg::REG_RHO:   rho_q   = longint'(cfg_data);
					les_pkg::REG_BETA:  beta_q  = longint'(cfg_data);
					les_pkg::REG_DT:    dt_q    = longint'(cfg_data);
					default: ;
				endcase
			end
		end
		outstanding <= expected_points.size();
		mismatches <= err_count;
	end

endmodule

// ----- bench/tb.sv -----
module tb;

	localparam int WW = les_pkg::WORD_WIDTH_DEF;
	localparam int FB = les_pkg::FRAC_BITS_DEF;
	localparam int DW = ((3 * WW + 7) / 8) * 8;
	localparam int CW = les_pkg::COEF_W;

	// Handy points in the word format.
	localparam logic [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
	localparam logic [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};
	localparam logic [WW-1:0] W_ONE = 1 << FB;

	// Coefficient settings: the reset defaults 10, 28, 8/3 and 0.02.
	localparam logic [CW-1:0] SIGMA_DEF = CW'(10 << FB);
	localparam logic [CW-1:0] RHO_DEF   = CW'(28 << FB);
	localparam logic [CW-1:0] BETA_DEF  = CW'(((8 << FB) + 1) / 3);
	localparam logic [CW-1:0] DT_DEF    = CW'(((1 << FB) + 25) / 50);
	localparam logic [CW-1:0] COEF_MAX  = {CW{1'b1}};

	localparam int ITEMS_PER_PHASE = 250;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [DW-1:0]                   s_tdata = '0;
	logic [0:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [DW-1:0]                   m_tdata;
	logic [0:0]                      m_tuser;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [les_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CW-1:0]                   cfg_data = '0;

	int mismatches;
	int outstanding;
	// Percent of cycles in which the source holds back a beat, and percent in
	// which the sink refuses one.
	int sender_idle_pct = 20;
	int receiver_stall_pct = 71;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	lorenz_euler_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	les_checker #(.DW(DW)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// The sink decides afresh at every edge whether it takes a result beat.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Offers one request beat, after a random number of idle cycles, and
	// returns at the edge where the unit takes it. The valid stays high when
	// the next beat follows without a gap, so it is never dropped and raised
	// within the same step.
	task automatic push_item(input logic kind, input logic [WW-1:0] px,
			input logic [WW-1:0] py, input logic [WW-1:0] pz);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {pz, py, px};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stops the source and waits until every predicted result has come back.
	// The wait begins with a clock edge, so the last accepted beat is counted.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Writes all four coefficient registers as back-to-back beats. Only
	// called while the unit is drained.
	task automatic load_coefs(input logic [CW-1:0] sg, input logic [CW-1:0] rh,
			input logic [CW-1:0] bt, input logic [CW-1:0] dt);
		logic [CW-1:0] vals [4];
		vals[les_pkg::REG_SIGMA] = sg;
		vals[les_pkg::REG_RHO]   = rh;
		vals[les_pkg::REG_BETA]  = bt;
		vals[les_pkg::REG_DT]    = dt;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= les_pkg::CFG_INDEX_W'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// Most beats are steps, so the point wanders along a trajectory. Loads
	// near the attractor restart it from fresh places, and a few loads with
	// arbitrary words push the arithmetic into clamping. The coordinates of
	// a step beat are random as well, since the unit must ignore them.
	task automatic random_items(input int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				push_item(les_pkg::REQ_STEP, $urandom, $urandom, $urandom);
			end else if (pick < 90) begin
				push_item(les_pkg::REQ_LOAD,
					WW'(int'($urandom_range(40 << FB)) - (20 << FB)),
					WW'(int'($urandom_range(50 << FB)) - (25 << FB)),
					WW'($urandom_range(50 << FB)));
			end else begin
				push_item(les_pkg::REQ_LOAD, $urandom, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, still at the reset coefficients. The first steps
		// start from the reset point (1, 1, 1).
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		push_item(les_pkg::REQ_STEP, '1, '1, '1);
		// The origin is a fixed point of the system.
		push_item(les_pkg::REQ_LOAD, '0, '0, '0);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		// Word extremes: the step has to clamp and raise the flag.
		push_item(les_pkg::REQ_LOAD, W_MAX, W_MAX, W_MAX);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		push_item(les_pkg::REQ_LOAD, W_MIN, W_MIN, W_MIN);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		push_item(les_pkg::REQ_LOAD, W_MAX, W_MIN, '0);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		push_item(les_pkg::REQ_LOAD, W_MIN, W_MAX, W_MAX);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		// Alternating bit patterns in every coordinate.
		push_item(les_pkg::REQ_LOAD, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		// Tiny negative values: the products truncate toward minus infinity.
		push_item(les_pkg::REQ_LOAD, '1, '1, '1);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		// A point on the attractor, followed by a few ordinary steps, one of
		// them carrying coordinates that must be ignored.
		push_item(les_pkg::REQ_LOAD, -(8 << FB), (15 << FB) >> 1, 27 << FB);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		push_item(les_pkg::REQ_STEP, W_MAX, W_MIN, W_ONE);
		push_item(les_pkg::REQ_STEP, '0, '0, '0);
		drain();

		// Random part in six phases. The idle pattern changes every two
		// phases, and the coefficients change at each phase boundary while
		// nothing is in flight.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					sender_idle_pct = 20;
					receiver_stall_pct <= 71;
				end
				1: begin
					sender_idle_pct = 71;
					receiver_stall_pct <= 20;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_stall_pct <= 0;
				end
			endcase
			case (ph)
				0: load_coefs(SIGMA_DEF, RHO_DEF, BETA_DEF, DT_DEF);
				1: load_coefs(CW'($urandom_range(20 << FB)), CW'($urandom_range(50 << FB)),
					CW'($urandom_range(5 << FB)), CW'($urandom_range(DT_DEF * 2)));
				2: load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
				3: load_coefs('0, '0, '0, '0);
				4: load_coefs(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
				default: load_coefs(SIGMA_DEF, RHO_DEF, BETA_DEF, DT_DEF);
			endcase
			random_items(ITEMS_PER_PHASE);
			drain();
		end

		// This extra wait gives any late extra beat time to show up.
		repeat (30) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Watchdog: a correct run ends long before this.
	initial begin
		#10_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/les_pkg.sv
rtl/les_ctrl.sv
rtl/les_dp.sv
rtl/lorenz_euler_step_unit.sv
rtl/les_checker.sv
bench/les_checker.sv
bench/tb.sv
